// ===== rtl/cpq_pkg.sv =====
package cpq_pkg;

  // Storage depth of the departure buffer (one cell per entry).
  localparam int QUEUE_DEPTH = 256;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W  = 64;
  localparam int DELAY_W = 32;
  localparam int LIMIT_W = 8;
  localparam int DEST_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CREDIT_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RESET = 8'd8;

  typedef struct packed {
    logic              is_credit;
    logic [TIME_W-1:0] now_ns;
    logic [TIME_W-1:0] packet_time_ns;
    logic [DEST_W-1:0] dest_id;
  } cpq_in_t;

  typedef struct packed {
    logic              forwarded;
    logic [TIME_W-1:0] depart_ns;
    logic [DEST_W-1:0] out_dest_id;
    logic              out_is_credit;
  } cpq_out_t;

  // Control broadcast to every cell of the buffer.
  typedef struct packed {
    logic shift;   // pop the head: every cell takes its neighbour's entry
    logic push;    // the first empty cell takes push_value
  } cell_ctrl_t;

endpackage

// ===== rtl/cpq_cell.sv =====
module cpq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  cpq_pkg::cell_ctrl_t       ctrl,
  input  logic [cpq_pkg::TIME_W-1:0] push_value,
  input  logic                      prev_valid,
  input  logic                      next_valid,
  input  logic [cpq_pkg::TIME_W-1:0] next_value,
  output logic                      valid,
  output logic [cpq_pkg::TIME_W-1:0] value
);
  import cpq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.push && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_value;
    end else if (ctrl.push && !valid && prev_valid) begin
      value <= push_value;
    end
  end

endmodule

// ===== rtl/credit_pacing_queue.sv =====
// Credit pacing queue: rate limiter for credit packets at a switch port.
//
// Item channel: start / busy / item. A word is taken at a rising edge with
// start high and busy low. Result channel: done / result. Each result word
// is shown for exactly one cycle with done high; the receiver cannot stall
// it, so nothing is ever held back on the output side.
// Configuration: cfg_we / cfg_index / cfg_data, one register per edge; the user
// must write only while busy is low and no result is outstanding; the block does not enforce this.
//
// Handling by packet kind:
//   data packet   - result registered and shown in the cycle after acceptance;
//                   busy stays low, so a new word can be taken every cycle.
//   credit packet - DRAIN pops expired credits from the head, one per cycle;
//                   ADD registers the result of a drop, PUSH that of a forward.
//                   busy falls as the result is shown, so the next word can
//                   be taken that same cycle.
// The departure buffer is a row of QUEUE_DEPTH cells; a pop shifts the whole
// row one place toward the head, a push fills the first empty cell.
//
// Reset (rst, synchronous): buffer emptied, slot cleared, registers back to
// delay 0, gap 0, limit 8. No clearing pass is needed.
module credit_pacing_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cpq_pkg::cpq_in_t              item,
  input  logic                          cfg_we,
  input  logic [cpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpq_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output cpq_pkg::cpq_out_t             result
);
  import cpq_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DRAIN,   // pop expired credits, one per cycle
    ADD,     // room check result known; form departure time
    PUSH     // store credit, advance slot, show result
  } state_t;

  state_t state;

  // configuration registers
  logic [DELAY_W-1:0] process_delay_ns;
  logic [DELAY_W-1:0] credit_gap_ns;
  logic [LIMIT_W-1:0] buffer_limit;

  // working registers
  cpq_in_t           word;        // captured credit word
  logic [CNT_W-1:0]  count;       // credits held in the row
  logic [TIME_W-1:0] next_slot_ns;
  logic [TIME_W-1:0] base;        // max(slot, now)
  logic              room;
  logic [TIME_W-1:0] depart;

  // cell row
  cell_ctrl_t        ctrl;
  logic              cell_valid [QUEUE_DEPTH];
  logic [TIME_W-1:0] cell_value [QUEUE_DEPTH];

  logic [CNT_W-1:0]  eff_limit;
  logic              head_expired;

  // limit is capped at the storage depth
  always_comb begin
    if (32'(buffer_limit) > QUEUE_DEPTH) begin
      eff_limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      eff_limit = CNT_W'(buffer_limit);
    end
  end

  // head of the row is cell 0; count tracks occupancy, so only the head
  // compare is needed to decide a pop
  assign head_expired = (count != '0) && (cell_value[0] <= word.now_ns);

  always_comb begin
    ctrl.shift = (state == DRAIN) && head_expired;
    ctrl.push  = (state == PUSH);
  end

  assign busy = (state != IDLE);

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic              pv;
      logic              nv;
      logic [TIME_W-1:0] nval;
      if (i == 0) begin : g_first
        assign pv = 1'b1;
      end else begin : g_mid
        assign pv = cell_valid[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign nv   = 1'b0;
        assign nval = cell_value[i];
      end else begin : g_inner
        assign nv   = cell_valid[i+1];
        assign nval = cell_value[i+1];
      end
      cpq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .push_value (depart),
        .prev_valid (pv),
        .next_valid (nv),
        .next_value (nval),
        .valid      (cell_valid[i]),
        .value      (cell_value[i])
      );
    end
  endgenerate

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      process_delay_ns <= '0;
      credit_gap_ns    <= '0;
      buffer_limit     <= BUFFER_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_DELAY: process_delay_ns <= cfg_data[DELAY_W-1:0];
        REG_CREDIT_GAP:    credit_gap_ns    <= cfg_data[DELAY_W-1:0];
        REG_BUFFER_LIMIT:  buffer_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      count        <= '0;
      next_slot_ns <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            word <= item;
            if (item.is_credit) begin
              state <= DRAIN;
            end else begin
              // data word passes straight through
              result.forwarded     <= 1'b1;
              result.depart_ns     <= item.packet_time_ns;
              result.out_dest_id   <= item.dest_id;
              result.out_is_credit <= 1'b0;
              done                 <= 1'b1;
            end
          end
        end
        DRAIN: begin
          if (head_expired) begin
            count <= count - CNT_W'(1);
          end else begin
            base  <= (next_slot_ns > word.now_ns) ? next_slot_ns : word.now_ns;
            room  <= (count < eff_limit);
            state <= ADD;
          end
        end
        ADD: begin
          if (room) begin
            depart <= base + TIME_W'(process_delay_ns);
            state  <= PUSH;
          end else begin
            // buffer full: drop
            result.forwarded     <= 1'b0;
            result.depart_ns     <= '0;
            result.out_dest_id   <= '0;
            result.out_is_credit <= 1'b1;
            done                 <= 1'b1;
            state                <= IDLE;
          end
        end
        PUSH: begin
          count                <= count + CNT_W'(1);
          next_slot_ns         <= depart + TIME_W'(credit_gap_ns);
          result.forwarded     <= 1'b1;
          result.depart_ns     <= depart;
          result.out_dest_id   <= word.dest_id;
          result.out_is_credit <= 1'b1;
          done                 <= 1'b1;
          state                <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cpq_checker.sv =====
module cpq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input cpq_pkg::cpq_in_t  item,
  input logic              done,
  input cpq_pkg::cpq_out_t result
);
  import cpq_pkg::*;

  // a data word comes back the next cycle, unchanged
  a_data_pass: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.is_credit |=>
      done && result.forwarded && !result.out_is_credit
      && result.depart_ns == $past(item.packet_time_ns)
      && result.out_dest_id == $past(item.dest_id))
    else $error("data word not passed through");

  // a credit word always occupies the sequencer
  a_credit_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.is_credit |=> busy && !done)
    else $error("credit word did not start the sequencer");

  // a dropped credit carries zeros
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.forwarded |->
      result.out_is_credit && result.depart_ns == '0 && result.out_dest_id == '0)
    else $error("dropped credit with non-zero payload");

  // finishing a credit always gives its result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done && result.out_is_credit)
    else $error("credit finished without result");

endmodule

bind credit_pacing_queue cpq_checker u_cpq_checker (.*);
